// ===== rtl/core/csk_pkg.sv =====
package csk_pkg;

  // Offsets whose magnitude exceeds this along either axis lie beyond the mask.
  localparam int MaxRadius = 64;

  localparam int OffW  = 8;
  localparam int AbsW  = 8;
  localparam int D2W   = 16;
  localparam int IhrW  = 18;
  localparam int NormW = 32;
  localparam int P1W   = D2W + IhrW;
  localparam int P2W   = P1W + IhrW;

  // Only squared distances below 4.0 in Q.32 reach the square root.
  localparam int RadW  = 34;

  // Square root: two radicand bits per iteration, three iterations per stage.
  localparam int SqPairs         = 18;
  localparam int SqStepsPerStage = 3;
  localparam int SqStages        = SqPairs / SqStepsPerStage;
  localparam int ArgW            = 2 * SqPairs;
  localparam int RootW           = SqPairs;
  localparam int RemW            = RootW + 4;

  localparam int QW    = 17;
  localparam int SqrW  = 2 * QW;
  localparam int CubeW = SqrW + QW;
  localparam int NumW  = 52;
  localparam int PolyW = 17;
  localparam int ProdW = NormW + PolyW;
  localparam int WgtW  = 32;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgInvHalfRadius = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgNormScale     = 1'd1;

  localparam logic [IhrW-1:0]  IhrReset  = 18'd65536;
  localparam logic [NormW-1:0] NormReset = 32'd65536;

  typedef enum logic [1:0] {
    RegionInner   = 2'd0,
    RegionOuter   = 2'd1,
    RegionOutside = 2'd2
  } csk_region_t;

  typedef struct packed {
    logic signed [OffW-1:0] offset_x;
    logic signed [OffW-1:0] offset_y;
  } csk_in_t;

  typedef struct packed {
    logic [WgtW-1:0] weight;
    logic [1:0]      region;
  } csk_out_t;

  // Squared scaled distance, with hit low when the offset is beyond the mask
  // or the distance is at least 2.0.
  typedef struct packed {
    logic            hit;
    logic [RadW-1:0] rad;
  } csk_rad_t;

  typedef struct packed {
    logic          hit;
    logic [QW-1:0] root;
  } csk_root_t;

  typedef struct packed {
    csk_region_t      region;
    logic [PolyW-1:0] poly;
  } csk_poly_t;

endpackage

// ===== rtl/core/cubic_spline_kernel_weight.sv =====
// Channel   Ports                                  Payload
// input     in_valid, in_stall, in_data            offset_x, offset_y (signed 8 bit)
// result    out_valid, out_stall, out_data         weight (Q16.16), region
// config    cfg_we, cfg_index, cfg_data            inv_half_radius, norm_scale
//
// One transfer is accepted per cycle while the pipeline is not stalled.
// The pipeline has 14 register stages: three for the squared distance,
// six for the square root (three root bits each) and five for polynomial and scaling.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. A stall closes bubbles first and holds every item in place.
module cubic_spline_kernel_weight (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  csk_pkg::csk_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output csk_pkg::csk_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [csk_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [csk_pkg::CfgDataW-1:0]    cfg_data
);
  import csk_pkg::*;

  // Configuration registers. The user must write them only while the pipeline is
  // empty; the block does not enforce it. So they need no copy travelling with items.
  logic [IhrW-1:0]  ihr_r;
  logic [NormW-1:0] norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ihr_r  <= IhrReset;
      norm_r <= NormReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgInvHalfRadius: ihr_r  <= cfg_data[IhrW-1:0];
        CfgNormScale:     norm_r <= cfg_data[NormW-1:0];
        default:          ;
      endcase
    end
  end

  logic      dist_up_en, dist_valid, sqrt_up_en;
  csk_rad_t  dist_data;
  logic      sqrt_valid, poly_up_en;
  csk_root_t sqrt_data;
  logic      poly_valid, out_en;
  csk_poly_t poly_data;

  // The squared offset distance is scaled twice by the reciprocal half-radius, giving
  // q squared in Q.32, marked as a miss when q is 2.0 or more or beyond the mask.
  csk_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ihr      (ihr_r),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_en    (dist_up_en),
    .dn_valid (dist_valid),
    .dn_data  (dist_data),
    .dn_en    (sqrt_up_en)
  );

  // The pipelined square root returns q in Q.16, the exact floor of the true value.
  csk_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dist_valid),
    .up_data  (dist_data),
    .up_en    (sqrt_up_en),
    .dn_valid (sqrt_valid),
    .dn_data  (sqrt_data),
    .dn_en    (poly_up_en)
  );

  // The region is chosen and the spline polynomial evaluated in Q.16.
  csk_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sqrt_valid),
    .up_data  (sqrt_data),
    .up_en    (poly_up_en),
    .dn_valid (poly_valid),
    .dn_data  (poly_data),
    .dn_en    (out_en)
  );

  // Output register: the polynomial is scaled by the normalisation constant
  // and saturated at the largest Q16.16 value.
  logic [ProdW-1:0]  prod;
  logic [WgtW:0]     wide;
  logic [WgtW-1:0]   weight;
  logic              out_valid_r;
  csk_out_t          out_r;

  assign out_en = !out_valid_r || !out_stall;

  always_comb begin
    prod   = ProdW'(norm_r) * ProdW'(poly_data.poly);
    wide   = prod[ProdW-1:16];
    weight = wide[WgtW] ? {WgtW{1'b1}} : wide[WgtW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= poly_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && poly_valid) begin
      out_r.weight <= weight;
      out_r.region <= poly_data.region;
    end
  end

  assign in_stall  = !dist_up_en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/csk_dist.sv =====
module csk_dist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [csk_pkg::IhrW-1:0]      ihr,
  input  logic                          up_valid,
  input  csk_pkg::csk_in_t              up_data,
  output logic                          up_en,
  output logic                          dn_valid,
  output csk_pkg::csk_rad_t             dn_data,
  input  logic                          dn_en
);
  import csk_pkg::*;

  logic [AbsW-1:0] ax, ay;
  logic [D2W-1:0]  d2_sum;
  logic            inr;
  logic [P1W-1:0]  p1;
  logic [P2W-1:0]  p2;

  logic            va_r, vb_r, vc_r;
  logic [D2W-1:0]  d2_r;
  logic            inra_r, inrb_r;
  logic [P1W-1:0]  p1_r;
  csk_rad_t        rad_r;
  logic            en_a, en_b, en_c;

  assign en_c  = !vc_r || dn_en;
  assign en_b  = !vb_r || en_c;
  assign en_a  = !va_r || en_b;
  assign up_en = en_a;

  always_comb begin
    ax     = up_data.offset_x[OffW-1] ? AbsW'(~up_data.offset_x + 8'sd1)
                                      : AbsW'(up_data.offset_x);
    ay     = up_data.offset_y[OffW-1] ? AbsW'(~up_data.offset_y + 8'sd1)
                                      : AbsW'(up_data.offset_y);
    inr    = (32'(ax) <= MaxRadius) && (32'(ay) <= MaxRadius);
    d2_sum = D2W'(ax) * D2W'(ax) + D2W'(ay) * D2W'(ay);
    p1     = P1W'(d2_r) * P1W'(ihr);
    p2     = P2W'(p1_r) * P2W'(ihr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      d2_r   <= d2_sum;
      inra_r <= inr;
    end
    if (en_b && va_r) begin
      p1_r   <= p1;
      inrb_r <= inra_r;
    end
    if (en_c && vb_r) begin
      rad_r.hit <= inrb_r && (p2[P2W-1:RadW] == '0);
      rad_r.rad <= p2[RadW-1:0];
    end
  end

  assign dn_valid = vc_r;
  assign dn_data  = rad_r;

endmodule

// ===== rtl/core/csk_sqrt.sv =====
module csk_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  csk_pkg::csk_rad_t  up_data,
  output logic               up_en,
  output logic               dn_valid,
  output csk_pkg::csk_root_t dn_data,
  input  logic               dn_en
);
  import csk_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [ArgW-1:0]  arg;
    logic [RootW-1:0] root;
    logic [RemW-1:0]  rem;
  } sq_t;

  // Three iterations of the restoring digit recurrence, two radicand bits each.
  function automatic sq_t sq_step(sq_t s);
    sq_t             t;
    logic [RemW-1:0] trial;
    t = s;
    for (int j = 0; j < SqStepsPerStage; j++) begin
      t.rem = {t.rem[RemW-3:0], t.arg[ArgW-1 -: 2]};
      t.arg = {t.arg[ArgW-3:0], 2'b00};
      trial = RemW'({t.root, 2'b01});
      if (t.rem >= trial) begin
        t.rem  = t.rem - trial;
        t.root = {t.root[RootW-2:0], 1'b1};
      end else begin
        t.root = {t.root[RootW-2:0], 1'b0};
      end
    end
    return t;
  endfunction

  sq_t  st_r   [SqStages];
  sq_t  st_nxt [SqStages];
  logic vld_r  [SqStages];
  logic en     [SqStages+1];
  sq_t  init;

  always_comb begin
    init.hit  = up_data.hit;
    init.arg  = ArgW'(up_data.rad);
    init.root = '0;
    init.rem  = '0;
    st_nxt[0] = sq_step(init);
    for (int k = 1; k < SqStages; k++) begin
      st_nxt[k] = sq_step(st_r[k-1]);
    end
  end

  always_comb begin
    en[SqStages] = dn_en;
    for (int k = SqStages - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SqStages; k++) vld_r[k] <= 1'b0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < SqStages; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && up_valid) st_r[0] <= st_nxt[0];
    for (int k = 1; k < SqStages; k++) begin
      if (en[k] && vld_r[k-1]) st_r[k] <= st_nxt[k];
    end
  end

  assign up_en        = en[0];
  assign dn_valid     = vld_r[SqStages-1];
  assign dn_data.hit  = st_r[SqStages-1].hit;
  assign dn_data.root = st_r[SqStages-1].root[QW-1:0];

endmodule

// ===== rtl/core/csk_poly.sv =====
module csk_poly (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  csk_pkg::csk_root_t up_data,
  output logic               up_en,
  output logic               dn_valid,
  output csk_pkg::csk_poly_t dn_data,
  input  logic               dn_en
);
  import csk_pkg::*;

  localparam logic [QW-1:0]   TwoQ16   = QW'(131072);
  localparam logic [NumW-1:0] FourCube = NumW'(1) << 50;

  logic va_r, vb_r, vc_r, vd_r;
  logic en_a, en_b, en_c, en_d;

  csk_region_t       reg_a_r, reg_b_r, reg_c_r;
  logic [QW-1:0]     m_a_r, m_b_r;
  logic [SqrW-1:0]   sq_b_r, sq_c_r;
  logic [CubeW-1:0]  cu_c_r;
  csk_poly_t         res_r;

  csk_region_t       reg_a;
  logic [QW-1:0]     m_a;
  logic [NumW-1:0]   num;
  logic [PolyW-1:0]  poly;

  assign en_d  = !vd_r || dn_en;
  assign en_c  = !vc_r || en_d;
  assign en_b  = !vb_r || en_c;
  assign en_a  = !va_r || en_b;
  assign up_en = en_a;

  // Inner region evaluates in q, outer region in 2 - q, so one pair of
  // multipliers serves both.
  always_comb begin
    if (!up_data.hit) begin
      reg_a = RegionOutside;
      m_a   = '0;
    end else if (up_data.root[QW-1]) begin
      reg_a = RegionOuter;
      m_a   = TwoQ16 - up_data.root;
    end else begin
      reg_a = RegionInner;
      m_a   = up_data.root;
    end
    num = FourCube + NumW'(cu_c_r) * NumW'(3) - ((NumW'(sq_c_r) * NumW'(6)) << 16);
    if (reg_c_r == RegionInner) begin
      poly = num[50:34];
    end else if (reg_c_r == RegionOuter) begin
      poly = cu_c_r[50:34];
    end else begin
      poly = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      reg_a_r <= reg_a;
      m_a_r   <= m_a;
    end
    if (en_b && va_r) begin
      reg_b_r <= reg_a_r;
      m_b_r   <= m_a_r;
      sq_b_r  <= SqrW'(m_a_r) * SqrW'(m_a_r);
    end
    if (en_c && vb_r) begin
      reg_c_r <= reg_b_r;
      sq_c_r  <= sq_b_r;
      cu_c_r  <= CubeW'(sq_b_r) * CubeW'(m_b_r);
    end
    if (en_d && vc_r) begin
      res_r.region <= reg_c_r;
      res_r.poly   <= poly;
    end
  end

  assign dn_valid = vd_r;
  assign dn_data  = res_r;

endmodule
